// ===== rtl/core/sepws_pkg.sv =====
// Shared types, codes and helpers for the SPI EEPROM page-write sequencer.
package sepws_pkg;

  // Device geometry and command bytes.
  localparam int unsigned PageBytes  = 32;
  localparam int unsigned PageW      = $clog2(PageBytes);
  localparam int unsigned MaxResults = 6;
  localparam int unsigned ResCntW    = $clog2(MaxResults + 1);

  localparam logic [15:0] TimeoutReset = 16'd500;
  localparam logic [7:0]  CmdWren      = 8'h06;
  localparam logic [7:0]  CmdRdsr      = 8'h05;
  localparam logic [7:0]  CmdRead      = 8'h03;
  localparam logic [7:0]  CmdWrite     = 8'h02;
  localparam logic [7:0]  BusyBits     = 8'h03;

  // Kind of an input item.
  typedef enum logic [2:0] {
    ModeWrite  = 3'd0,
    ModeRead   = 3'd1,
    ModeStatus = 3'd2,
    ModeTick   = 3'd3,
    ModeFault  = 3'd4
  } sepws_mode_e;

  // Kind of a result item.
  typedef enum logic [2:0] {
    ActSend    = 3'd0,
    ActStatus  = 3'd1,
    ActData    = 3'd2,
    ActRelease = 3'd3,
    ActTimeout = 3'd4,
    ActFault   = 3'd5
  } sepws_action_e;

  // Sequencer phase, one-hot.
  typedef enum logic [4:0] {
    PhIdle      = 5'b00001,
    PhPollWrite = 5'b00010,
    PhPollRead  = 5'b00100,
    PhStream    = 5'b01000,
    PhBetween   = 5'b10000
  } sepws_phase_e;

  typedef struct packed {
    sepws_phase_e phase;
    logic [15:0]  next_address;
    logic [7:0]   held_byte;
    logic         held_last;
    logic [15:0]  pending_read_length;
    logic [15:0]  elapsed_ticks;
  } sepws_state_t;

  typedef struct packed {
    sepws_action_e action;
    logic [7:0]    spi_byte;
    logic [15:0]   receive_count;
    logic          cs_release;
    logic          run_end;
  } sepws_res_t;

  function automatic sepws_res_t res_mk(sepws_action_e act, logic [7:0] byte_v,
                                        logic [15:0] count, logic rel);
    sepws_res_t r;
    r.action        = act;
    r.spi_byte      = byte_v;
    r.receive_count = count;
    r.cs_release    = rel;
    r.run_end       = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/core/sepws_step.sv =====
// Next-state and result-list logic for one input item of the sequencer.
module sepws_step import sepws_pkg::*; (
  input  sepws_state_t state_i,
  input  logic [15:0]  timeout_i,
  input  logic [2:0]   mode_i,
  input  logic [15:0]  address_i,
  input  logic [7:0]   data_byte_i,
  input  logic         first_i,
  input  logic         last_i,
  input  logic [15:0]  read_length_i,
  output sepws_state_t state_o,
  output sepws_res_t   res_o [MaxResults],
  output logic [ResCntW-1:0] res_cnt_o
);

  logic        polling;
  logic        frame_open;
  logic [15:0] addr_inc;
  logic        boundary;
  logic [15:0] ticks_inc;

  assign polling    = (state_i.phase == PhPollWrite) || (state_i.phase == PhPollRead);
  assign frame_open = polling || (state_i.phase == PhStream);
  assign addr_inc   = state_i.next_address + 16'd1;
  assign boundary   = (addr_inc[PageW-1:0] == '0);
  assign ticks_inc  = (state_i.elapsed_ticks != 16'hFFFF) ?
                      state_i.elapsed_ticks + 16'd1 : state_i.elapsed_ticks;

  always_comb begin
    logic [ResCntW-1:0] n;
    logic               data_last;
    n         = '0;
    data_last = 1'b0;
    state_o   = state_i;
    for (int i = 0; i < MaxResults; i++) begin
      res_o[i] = res_mk(ActSend, 8'h00, 16'h0000, 1'b0);
    end

    case (mode_i)
      ModeWrite: begin
        if (first_i || (state_i.phase == PhBetween)) begin
          // A new transfer or the next page chunk: hold the byte and poll first.
          if (first_i) begin
            if (frame_open) begin
              res_o[n] = res_mk(ActRelease, 8'h00, 16'h0000, 1'b1);
              n = n + 1'b1;
            end
            state_o.next_address = address_i;
          end
          state_o.held_byte     = data_byte_i;
          state_o.held_last     = last_i;
          state_o.elapsed_ticks = '0;
          state_o.phase         = PhPollWrite;
          res_o[n] = res_mk(ActSend, CmdRdsr, 16'h0000, 1'b0);
          n = n + 1'b1;
          res_o[n] = res_mk(ActStatus, 8'h00, 16'h0000, 1'b0);
          n = n + 1'b1;
        end else if (state_i.phase == PhStream) begin
          state_o.next_address = addr_inc;
          res_o[n] = res_mk(ActSend, data_byte_i, 16'h0000, last_i || boundary);
          n = n + 1'b1;
          state_o.phase = last_i ? PhIdle : (boundary ? PhBetween : PhStream);
        end
      end
      ModeRead: begin
        if (frame_open) begin
          res_o[n] = res_mk(ActRelease, 8'h00, 16'h0000, 1'b1);
          n = n + 1'b1;
        end
        state_o.next_address        = address_i;
        state_o.pending_read_length = read_length_i;
        state_o.elapsed_ticks       = '0;
        state_o.phase               = PhPollRead;
        res_o[n] = res_mk(ActSend, CmdRdsr, 16'h0000, 1'b0);
        n = n + 1'b1;
        res_o[n] = res_mk(ActStatus, 8'h00, 16'h0000, 1'b0);
        n = n + 1'b1;
      end
      ModeStatus: begin
        if (polling) begin
          if (state_i.elapsed_ticks >= timeout_i) begin
            res_o[n] = res_mk(ActTimeout, 8'h00, 16'h0000, 1'b1);
            n = n + 1'b1;
            state_o.phase = PhIdle;
          end else if ((data_byte_i & BusyBits) != 8'h00) begin
            res_o[n] = res_mk(ActStatus, 8'h00, 16'h0000, 1'b0);
            n = n + 1'b1;
          end else begin
            res_o[n] = res_mk(ActRelease, 8'h00, 16'h0000, 1'b1);
            n = n + 1'b1;
            if (state_i.phase == PhPollWrite) begin
              res_o[n] = res_mk(ActSend, CmdWren, 16'h0000, 1'b1);
              n = n + 1'b1;
              res_o[n] = res_mk(ActSend, CmdWrite, 16'h0000, 1'b0);
              n = n + 1'b1;
            end else begin
              res_o[n] = res_mk(ActSend, CmdRead, 16'h0000, 1'b0);
              n = n + 1'b1;
            end
            res_o[n] = res_mk(ActSend, state_i.next_address[15:8], 16'h0000, 1'b0);
            n = n + 1'b1;
            res_o[n] = res_mk(ActSend, state_i.next_address[7:0], 16'h0000, 1'b0);
            n = n + 1'b1;
            if (state_i.phase == PhPollWrite) begin
              // First data byte of the chunk goes out in the new frame.
              data_last = state_i.held_last;
              state_o.next_address = addr_inc;
              res_o[n] = res_mk(ActSend, state_i.held_byte, 16'h0000,
                                data_last || boundary);
              n = n + 1'b1;
              state_o.phase = data_last ? PhIdle : (boundary ? PhBetween : PhStream);
            end else begin
              res_o[n] = res_mk(ActData, 8'h00, state_i.pending_read_length, 1'b1);
              n = n + 1'b1;
              state_o.phase = PhIdle;
            end
          end
        end
      end
      ModeTick: begin
        if (polling) begin
          state_o.elapsed_ticks = ticks_inc;
          if (ticks_inc >= timeout_i) begin
            res_o[n] = res_mk(ActTimeout, 8'h00, 16'h0000, 1'b1);
            n = n + 1'b1;
            state_o.phase = PhIdle;
          end
        end
      end
      ModeFault: begin
        if (state_i.phase != PhIdle) begin
          res_o[n] = res_mk(ActFault, 8'h00, 16'h0000, 1'b1);
          n = n + 1'b1;
          state_o.phase = PhIdle;
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase

    if (n != '0) begin
      res_o[n - 1'b1].run_end = 1'b1;
    end
    res_cnt_o = n;
  end

endmodule

// ===== rtl/core/spi_eeprom_page_write_sequencer.sv =====
// Top level of the SPI EEPROM page-write and read command sequencer.
//
//   Channel   Direction  Handshake              Carries
//   s_axis    in         tvalid/tready          one request: write byte, read, status, tick, fault
//   m_axis    out        tvalid/tready          one SPI action for the bus engine
//   cfg       in         cfg_we_i (no wait)     poll timeout in ticks
//
// An accepted item is evaluated in the same cycle by the step logic, the state registers
// take their next value, and the whole list of up to six result items is loaded into a
// small result queue that drains one item per cycle on m_axis unless it is stalled.
// A new item is taken when the queue is empty or its last entry leaves in that cycle,
// so an item with zero or one result follows the previous one back to back; an item
// with more results holds s_axis off until its last one leaves. Reset puts the sequencer
// idle with an empty queue and the timeout at 500 ticks. A stall on m_axis holds the
// queue head and back-pressures s_axis once the queue is not about to empty.
module spi_eeprom_page_write_sequencer import sepws_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Bits from the lowest up: address[15:0], data_byte[23:16], first[24],
  // read_length[40:25], zero fill [47:41].
  input  logic [47:0] s_axis_tdata,
  // Bits from the lowest up: mode[2:0].
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tlast,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Bits from the lowest up: spi_byte[7:0], receive_count[23:8], cs_release[24],
  // zero fill [31:25].
  output logic [31:0] m_axis_tdata,
  // Bits from the lowest up: action[2:0].
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast,

  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  sepws_state_t       state_q, state_d;
  logic [15:0]        timeout_q;
  sepws_res_t         res_q [MaxResults];
  sepws_res_t         step_res [MaxResults];
  logic [ResCntW-1:0] cnt_q;
  logic [ResCntW-1:0] step_cnt;
  logic               in_take;
  logic               out_take;

  assign out_take      = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (cnt_q == '0) || ((cnt_q == ResCntW'(1)) && m_axis_tready);
  assign in_take       = s_axis_tvalid && s_axis_tready;

  sepws_step u_step (
    .state_i       (state_q),
    .timeout_i     (timeout_q),
    .mode_i        (s_axis_tuser),
    .address_i     (s_axis_tdata[15:0]),
    .data_byte_i   (s_axis_tdata[23:16]),
    .first_i       (s_axis_tdata[24]),
    .last_i        (s_axis_tlast),
    .read_length_i (s_axis_tdata[40:25]),
    .state_o       (state_d),
    .res_o         (step_res),
    .res_cnt_o     (step_cnt)
  );

  // Sequencer state and timeout register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase               <= PhIdle;
      state_q.next_address        <= '0;
      state_q.held_byte           <= '0;
      state_q.held_last           <= 1'b0;
      state_q.pending_read_length <= '0;
      state_q.elapsed_ticks       <= '0;
      timeout_q                   <= TimeoutReset;
    end else begin
      if (in_take) begin
        state_q <= state_d;
      end
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  // Result queue fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_take) begin
      cnt_q <= step_cnt;
    end else if (out_take) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Result queue entries: loaded as a block, shifted toward the head as items leave.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      res_q <= step_res;
    end else if (out_take) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
    end
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tuser  = res_q[0].action;
  assign m_axis_tlast  = res_q[0].run_end;
  assign m_axis_tdata  = {7'b0, res_q[0].cs_release, res_q[0].receive_count,
                          res_q[0].spi_byte};

endmodule

// ===== verif/spi_eeprom_page_write_sequencer_tb.sv =====
// Self-checking testbench for the SPI EEPROM page-write and read command sequencer.
module spi_eeprom_page_write_sequencer_tb;
  import sepws_pkg::*;

  // Generous run limit. Every item waits out a random send gap, and each of its
  // results waits out a random receiver stall.
  localparam int unsigned CycleLimit   = 400000;
  // Results come out of a short queue, so this settle covers any item still in flight.
  localparam int          SettleCycles = 8;
  localparam int          MaxPrinted   = 60;

  // Request kinds the block is meant to ignore.
  localparam logic [2:0] ModeSpareLo = 3'd5;
  localparam logic [2:0] ModeSpareHi = 3'd7;

  // One request as the sender sees it, before packing onto s_axis.
  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] address;
    logic [7:0]  data_byte;
    logic        first;
    logic        last;
    logic [15:0] read_length;
  } eeprom_req_t;

  // Scoreboard: tracks the sequencer's state, predicts the SPI actions each
  // accepted request causes, and matches them in order against the output stream.
  class eeprom_cmd_scoreboard;
    sepws_phase_e phase;
    logic [15:0]  next_addr;
    logic [7:0]   held_byte;
    logic         held_last;
    logic [15:0]  read_len;
    logic [15:0]  ticks;
    logic [15:0]  timeout_ticks;
    sepws_res_t   step_q[$];
    sepws_res_t   expected_q[$];
    int           errors;

    function new();
      phase         = PhIdle;
      next_addr     = '0;
      held_byte     = '0;
      held_last     = 1'b0;
      read_len      = '0;
      ticks         = '0;
      timeout_ticks = TimeoutReset;
      errors        = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void emit(sepws_action_e act, logic [7:0] b, logic [15:0] cnt, logic rel);
      sepws_res_t res;
      res.action        = act;
      res.spi_byte      = b;
      res.receive_count = cnt;
      res.cs_release    = rel;
      res.run_end       = 1'b0;
      step_q.push_back(res);
    endfunction

    // A new transfer closes whatever frame is still open. Between pages the
    // select line is already high, so nothing is sent there.
    function void release_open_frame();
      if (phase == PhPollWrite || phase == PhPollRead || phase == PhStream)
        emit(ActRelease, 8'h00, 16'h0000, 1'b1);
    endfunction

    function void begin_poll(sepws_phase_e p);
      ticks = '0;
      phase = p;
      emit(ActSend, CmdRdsr, 16'h0000, 1'b0);
      emit(ActStatus, 8'h00, 16'h0000, 1'b0);
    endfunction

    // A data byte ends its frame on the page boundary or when it is the last one.
    function void send_data_byte(logic [7:0] b, logic is_last);
      logic boundary;
      next_addr = next_addr + 16'd1;
      boundary  = (next_addr % PageBytes) == 0;
      emit(ActSend, b, 16'h0000, is_last || boundary);
      if (is_last) phase = PhIdle;
      else if (boundary) phase = PhBetween;
      else phase = PhStream;
    endfunction

    // Returns 1 when the request did anything: caused actions or counted a tick.
    function bit note_request(eeprom_req_t r);
      bit polling;
      bit counted_tick;
      polling      = (phase == PhPollWrite) || (phase == PhPollRead);
      counted_tick = 1'b0;
      step_q.delete();
      case (r.mode)
        ModeWrite: begin
          if (r.first) begin
            release_open_frame();
            next_addr = r.address;
            held_byte = r.data_byte;
            held_last = r.last;
            begin_poll(PhPollWrite);
          end else if (phase == PhStream) begin
            send_data_byte(r.data_byte, r.last);
          end else if (phase == PhBetween) begin
            held_byte = r.data_byte;
            held_last = r.last;
            begin_poll(PhPollWrite);
          end
        end
        ModeRead: begin
          release_open_frame();
          next_addr = r.address;
          read_len  = r.read_length;
          begin_poll(PhPollRead);
        end
        ModeStatus: begin
          if (polling) begin
            if (ticks >= timeout_ticks) begin
              emit(ActTimeout, 8'h00, 16'h0000, 1'b1);
              phase = PhIdle;
            end else if ((r.data_byte & BusyBits) != 8'h00) begin
              emit(ActStatus, 8'h00, 16'h0000, 1'b0);
            end else begin
              emit(ActRelease, 8'h00, 16'h0000, 1'b1);
              if (phase == PhPollWrite) begin
                emit(ActSend, CmdWren, 16'h0000, 1'b1);
                emit(ActSend, CmdWrite, 16'h0000, 1'b0);
                emit(ActSend, next_addr[15:8], 16'h0000, 1'b0);
                emit(ActSend, next_addr[7:0], 16'h0000, 1'b0);
                send_data_byte(held_byte, held_last);
              end else begin
                emit(ActSend, CmdRead, 16'h0000, 1'b0);
                emit(ActSend, next_addr[15:8], 16'h0000, 1'b0);
                emit(ActSend, next_addr[7:0], 16'h0000, 1'b0);
                emit(ActData, 8'h00, read_len, 1'b1);
                phase = PhIdle;
              end
            end
          end
        end
        ModeTick: begin
          if (polling) begin
            counted_tick = 1'b1;
            if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
            if (ticks >= timeout_ticks) begin
              emit(ActTimeout, 8'h00, 16'h0000, 1'b1);
              phase = PhIdle;
            end
          end
        end
        ModeFault: begin
          if (phase != PhIdle) begin
            emit(ActFault, 8'h00, 16'h0000, 1'b1);
            phase = PhIdle;
          end
        end
        default: ;
      endcase
      if (step_q.size() > 0) step_q[step_q.size() - 1].run_end = 1'b1;
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
      return counted_tick || (step_q.size() > 0);
    endfunction

    task report_mismatch(string what);
      if (errors < MaxPrinted) $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_action(sepws_res_t got);
      sepws_res_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected action %0d byte %02h count %04h rel %0b end %0b",
                                  got.action, got.spi_byte, got.receive_count,
                                  got.cs_release, got.run_end));
        return;
      end
      want = expected_q.pop_front();
      if (got.action !== want.action || got.spi_byte !== want.spi_byte ||
          got.receive_count !== want.receive_count ||
          got.cs_release !== want.cs_release || got.run_end !== want.run_end)
        report_mismatch($sformatf(
          "action %0d/%0d byte %02h/%02h count %04h/%04h rel %0b/%0b end %0b/%0b (got/want)",
          got.action, want.action, got.spi_byte, want.spi_byte, got.receive_count,
          want.receive_count, got.cs_release, want.cs_release, got.run_end, want.run_end));
    endtask
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // Bits from the lowest up: address, data_byte, first, read_length, zero fill.
  logic [47:0] s_axis_tdata  = '0;
  // Bits from the lowest up: mode.
  logic [2:0]  s_axis_tuser  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // Bits from the lowest up: spi_byte, receive_count, cs_release, zero fill.
  logic [31:0] m_axis_tdata;
  // Bits from the lowest up: action.
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i      = 1'b0;
  logic [15:0] cfg_wdata_i   = '0;

  eeprom_cmd_scoreboard sb;
  int unsigned cycle_count = 0;
  // When set, both sides run back to back with no idle cycles.
  bit          no_idle     = 1'b0;

  spi_eeprom_page_write_sequencer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Output monitor. Values read at the edge are the ones the block saw at that edge,
  // since every input here changes through a nonblocking assignment.
  always @(posedge clk_i) begin
    sepws_res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.action        = sepws_action_e'(m_axis_tuser);
      got.spi_byte      = m_axis_tdata[7:0];
      got.receive_count = m_axis_tdata[23:8];
      got.cs_release    = m_axis_tdata[24];
      got.run_end       = m_axis_tlast;
      sb.check_action(got);
    end
  end

  // Receiver: before each result it stalls for a random number of cycles.
  initial begin : sink
    int stall;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  function automatic eeprom_req_t mk_req(logic [2:0] mode, logic [15:0] address,
                                         logic [7:0] data_byte, logic first, logic last,
                                         logic [15:0] read_length);
    eeprom_req_t r;
    r.mode        = mode;
    r.address     = address;
    r.data_byte   = data_byte;
    r.first       = first;
    r.last        = last;
    r.read_length = read_length;
    return r;
  endfunction

  // Start addresses lean toward the end of a page and the top of the address space,
  // so that page splits and the address wrap come up often.
  function automatic logic [15:0] draw_address();
    logic [15:0] a;
    a = 16'($urandom);
    case ($urandom_range(0, 3))
      0: a[PageW-1:0] = PageW'(PageBytes - 1 - $urandom_range(0, 3));
      1: a = 16'hFFFF - 16'($urandom_range(0, 40));
      default: ;
    endcase
    return a;
  endfunction

  // Mostly well-formed traffic steered by the predicted phase: a write or read
  // starts, the poll sees busy bytes and ticks, then goes ready and the data streams.
  // A small share is noise: faults, aborts, ignored kinds and stray bytes.
  function automatic eeprom_req_t draw_request();
    eeprom_req_t r;
    int pick;
    r.mode        = ModeWrite;
    r.address     = 16'($urandom);
    r.data_byte   = 8'($urandom);
    r.first       = 1'b0;
    r.last        = 1'b0;
    case ($urandom_range(0, 5))
      0: r.read_length = 16'h0000;
      1: r.read_length = 16'hFFFF;
      default: r.read_length = 16'($urandom);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      r.mode  = 3'($urandom_range(0, 7));
      r.first = 1'($urandom);
      r.last  = 1'($urandom);
      return r;
    end
    case (sb.phase)
      PhIdle: begin
        if (pick < 60) begin
          r.first   = 1'b1;
          r.last    = ($urandom_range(0, 5) == 0);
          r.address = draw_address();
        end else if (pick < 85) begin
          r.mode    = ModeRead;
          r.address = draw_address();
        end else begin
          r.mode = 3'($urandom_range(ModeWrite, ModeFault));
        end
      end
      PhPollWrite, PhPollRead: begin
        if (pick < 50) begin
          r.mode      = ModeStatus;
          r.data_byte = r.data_byte & ~BusyBits;
        end else if (pick < 68) begin
          r.mode           = ModeStatus;
          r.data_byte[1:0] = 2'($urandom_range(1, 3));
        end else if (pick < 88) begin
          r.mode = ModeTick;
        end else if (pick < 92) begin
          r.mode = ModeFault;
        end else if (pick < 96) begin
          r.first   = 1'b1;
          r.last    = 1'($urandom);
          r.address = draw_address();
        end else begin
          r.mode    = ModeRead;
          r.address = draw_address();
        end
      end
      default: begin
        if (pick < 88) begin
          r.last = ($urandom_range(0, 11) == 0);
        end else if (pick < 92) begin
          r.mode = ModeFault;
        end else if (pick < 96) begin
          r.first   = 1'b1;
          r.address = draw_address();
        end else begin
          r.mode    = ModeRead;
          r.address = draw_address();
        end
      end
    endcase
    return r;
  endfunction

  // Offers one request after a random gap and notes it once the block takes it.
  task automatic send_request(input eeprom_req_t r, output bit effective);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, r.read_length, r.first, r.data_byte, r.address};
    s_axis_tuser  <= r.mode;
    s_axis_tlast  <= r.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    effective = sb.note_request(r);
  endtask

  task automatic send_one(input eeprom_req_t r);
    bit effective;
    send_request(r, effective);
  endtask

  // Stops offering requests until every predicted action has come out,
  // then lets the block settle.
  task automatic idle_until_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_poll_timeout(input logic [15:0] ticks);
    idle_until_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ticks;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.timeout_ticks = ticks;
  endtask

  // Sends random traffic until the given number of requests have had an effect.
  task automatic run_random(input int count, input bit hold_midway);
    eeprom_req_t r;
    bit effective;
    bit held;
    int done_n;
    int sent;
    done_n = 0;
    sent   = 0;
    held   = 1'b0;
    while (done_n < count) begin
      if (sent % 24 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (hold_midway && !held && done_n >= count / 2) begin
        held = 1'b1;
        idle_until_drained();
      end
      r = draw_request();
      send_request(r, effective);
      sent++;
      if (effective) done_n++;
    end
    no_idle = 1'b0;
  endtask

  initial begin : stimulus
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Requests that an idle sequencer ignores.
    send_one(mk_req(ModeFault, 16'h0000, 8'h00, 1'b0, 1'b0, 16'h0000));
    send_one(mk_req(ModeTick, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 16'hFFFF));
    send_one(mk_req(ModeStatus, 16'h0000, 8'h00, 1'b0, 1'b0, 16'h0000));
    send_one(mk_req(ModeSpareLo, 16'h5A5A, 8'h5A, 1'b1, 1'b0, 16'h5A5A));
    send_one(mk_req(ModeSpareHi, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 16'hFFFF));
    send_one(mk_req(ModeWrite, 16'h1234, 8'hFF, 1'b0, 1'b1, 16'h0000));

    // Write that starts one byte short of the top of memory: busy poll, a tick,
    // then ready. The second byte wraps the address to zero and ends the page,
    // so the third byte needs a fresh poll.
    send_one(mk_req(ModeWrite, 16'hFFFE, 8'hFF, 1'b1, 1'b0, 16'h0000));
    send_one(mk_req(ModeStatus, 16'h0000, 8'h01, 1'b0, 1'b0, 16'h0000));
    send_one(mk_req(ModeTick, 16'h0000, 8'h00, 1'b0, 1'b0, 16'h0000));
    send_one(mk_req(ModeStatus, 16'h0000, 8'hFC, 1'b0, 1'b0, 16'h0000));
    send_one(mk_req(ModeWrite, 16'h0000, 8'h00, 1'b0, 1'b0, 16'h0000));
    send_one(mk_req(ModeWrite, 16'h0000, 8'hA5, 1'b0, 1'b1, 16'h0000));
    send_one(mk_req(ModeStatus, 16'h0000, 8'h02, 1'b0, 1'b0, 16'h0000));
    send_one(mk_req(ModeStatus, 16'h0000, 8'h00, 1'b0, 1'b0, 16'h0000));

    // Read of zero length, then a maximal read cut short by a new write.
    send_one(mk_req(ModeRead, 16'h1234, 8'h00, 1'b0, 1'b0, 16'h0000));
    send_one(mk_req(ModeStatus, 16'h0000, 8'h00, 1'b0, 1'b0, 16'h0000));
    send_one(mk_req(ModeRead, 16'hFFFF, 8'h00, 1'b0, 1'b0, 16'hFFFF));
    send_one(mk_req(ModeWrite, 16'h001F, 8'h5A, 1'b1, 1'b0, 16'h0000));
    // Only the two low status bits mean busy.
    send_one(mk_req(ModeStatus, 16'h0000, 8'h80, 1'b0, 1'b0, 16'h0000));
    // Between pages the frame is already closed, so a read needs no release.
    send_one(mk_req(ModeRead, 16'h8000, 8'h00, 1'b0, 1'b0, 16'h0001));
    send_one(mk_req(ModeFault, 16'h0000, 8'h00, 1'b0, 1'b0, 16'h0000));
    // Fault in the middle of a page.
    send_one(mk_req(ModeWrite, 16'h0040, 8'h11, 1'b1, 1'b0, 16'h0000));
    send_one(mk_req(ModeStatus, 16'h0000, 8'h00, 1'b0, 1'b0, 16'h0000));
    send_one(mk_req(ModeWrite, 16'h0000, 8'h22, 1'b0, 1'b0, 16'h0000));
    send_one(mk_req(ModeFault, 16'h0000, 8'h00, 1'b0, 1'b0, 16'h0000));

    // Timeout of one tick: a single tick ends the poll of a write and of a read.
    write_poll_timeout(16'd1);
    send_one(mk_req(ModeWrite, 16'h0100, 8'h33, 1'b1, 1'b1, 16'h0000));
    send_one(mk_req(ModeTick, 16'h0000, 8'h00, 1'b0, 1'b0, 16'h0000));
    send_one(mk_req(ModeRead, 16'h0200, 8'h00, 1'b0, 1'b0, 16'h0010));
    send_one(mk_req(ModeStatus, 16'h0000, 8'h03, 1'b0, 1'b0, 16'h0000));
    send_one(mk_req(ModeTick, 16'h0000, 8'h00, 1'b0, 1'b0, 16'h0000));
    run_random(50, 1'b0);

    write_poll_timeout(16'hFFFF);
    run_random(55, 1'b0);

    write_poll_timeout(16'($urandom_range(2, 8)));
    run_random(70, 1'b1);

    write_poll_timeout(TimeoutReset);
    run_random(50, 1'b0);

    idle_until_drained();
    if (sb.errors == 0 && sb.pending() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
